// ----- design/bsc_pkg.sv -----
package bsc_pkg;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_TEMP     = 2'd0,
        CFG_PRESS_LO = 2'd1,
        CFG_PRESS_HI = 2'd2,
        CFG_PRESS_P9 = 2'd3
    } bsc_cfg_e;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 64;
    localparam int unsigned CAL_T_W    = 48;
    localparam int unsigned RAW_W      = 20;

    // Fixed constants of the compensation formula
    localparam logic [63:0] FINE_OFFSET = 64'd128000;
    localparam logic [63:0] PRESS_BASE  = 64'd1048576;
    localparam logic [63:0] VAR1_BIAS   = 64'h0000_8000_0000_0000;

    // Pipeline depth: restoring divider, one quotient bit per stage
    localparam int unsigned DIV_STAGES = 64;

    // Stage numbers along the pressure pipeline (after the temperature part)
    localparam int unsigned ST_ADCP  = 6;
    localparam int unsigned ST_DIVIN = 9;
    localparam int unsigned ST_QUO   = ST_DIVIN + DIV_STAGES + 1;
    localparam int unsigned ST_LAST  = ST_QUO + 5;

    // Data that rides along with each item
    typedef struct packed {
        logic [31:0]      temp;
        logic [RAW_W-1:0] adcp;
    } bsc_side_t;

    // Sign and zero-divisor flags carried through the divider
    typedef struct packed {
        logic neg;
        logic zero;
    } bsc_div_tag_t;

    function automatic logic [31:0] sar32(input logic [31:0] x, input int unsigned n);
        return 32'($signed(x) >>> n);
    endfunction

    function automatic logic [63:0] sar64(input logic [63:0] x, input int unsigned n);
        return 64'($signed(x) >>> n);
    endfunction

    function automatic logic [63:0] sext16(input logic [15:0] h);
        return {{48{h[15]}}, h};
    endfunction

endpackage

// ----- design/barometric_sensor_compensation.sv -----
// Fully pipelined compensation of one raw temperature and one raw pressure
// reading. An item is taken in every cycle (busy stays low), and its result
// appears with done, one result per item in order. The latency is set by
// the 64-stage restoring divider that forms one quotient bit per stage; the
// rest is registered 64-bit multipliers and adds.
// Results cannot be held off: they are valid for the single done cycle.
// Calibration words are read live, so write them only while no item is in
// flight.
module barometric_sensor_compensation (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [bsc_pkg::RAW_W-1:0]      raw_pressure,
    input  logic [bsc_pkg::RAW_W-1:0]      raw_temperature,
    input  logic                           cfg_we,
    input  logic [bsc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bsc_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output logic                           done,
    output logic signed [31:0]             temperature_centi,
    output logic [31:0]                    pressure_q24_8,
    output logic                           pressure_valid
);
    import bsc_pkg::*;

    // Calibration registers
    logic [CAL_T_W-1:0] cal_t_reg;
    logic [63:0]        cal_p_lo_reg;
    logic [63:0]        cal_p_hi_reg;
    logic [15:0]        cal_p9_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_t_reg    <= '0;
            cal_p_lo_reg <= '0;
            cal_p_hi_reg <= '0;
            cal_p9_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TEMP:     cal_t_reg    <= cfg_wdata[CAL_T_W-1:0];
                CFG_PRESS_LO: cal_p_lo_reg <= cfg_wdata;
                CFG_PRESS_HI: cal_p_hi_reg <= cfg_wdata;
                CFG_PRESS_P9: cal_p9_reg   <= cfg_wdata[15:0];
                default:      cal_p9_reg   <= cal_p9_reg;
            endcase
        end
    end

    logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
    assign p1 = {48'd0, cal_p_lo_reg[15:0]};
    assign p2 = sext16(cal_p_lo_reg[31:16]);
    assign p3 = sext16(cal_p_lo_reg[47:32]);
    assign p4 = sext16(cal_p_lo_reg[63:48]);
    assign p5 = sext16(cal_p_hi_reg[15:0]);
    assign p6 = sext16(cal_p_hi_reg[31:16]);
    assign p7 = sext16(cal_p_hi_reg[47:32]);
    assign p8 = sext16(cal_p_hi_reg[63:48]);
    assign p9 = sext16(cal_p9_reg);

    // Always ready: one item per cycle
    assign busy = 1'b0;

    // Temperature part
    logic        t_valid;
    logic [31:0] t_fine;
    bsc_side_t   t_side;

    bsc_temp u_temp (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (start & ~busy),
        .raw_temperature (raw_temperature),
        .raw_pressure    (raw_pressure),
        .cal             (cal_t_reg),
        .out_valid       (t_valid),
        .fine            (t_fine),
        .side            (t_side)
    );

    // Sideband and valid line along the pressure pipeline
    bsc_side_t side_reg [1:ST_LAST];
    logic      vld_reg  [1:ST_LAST];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 1; k <= ST_LAST; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else
        begin
            vld_reg[1] <= t_valid;
            for (int k = 2; k <= ST_LAST; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        side_reg[1] <= t_side;
        for (int k = 2; k <= ST_LAST; k++)
        begin
            side_reg[k] <= side_reg[k-1];
        end
    end

    // Stage 1: var1 = fine - 128000
    logic [63:0] w1_reg;
    always_ff @(posedge clk)
    begin
        w1_reg <= {{32{t_fine[31]}}, t_fine} - FINE_OFFSET;
    end

    // Stages 2-3: w1^2, w1*P5, w1*P2
    logic [63:0] sq, m5, m2;
    bsc_mul64 u_sq (.clk(clk), .a(w1_reg), .b(w1_reg), .p(sq));
    bsc_mul64 u_m5 (.clk(clk), .a(w1_reg), .b(p5),     .p(m5));
    bsc_mul64 u_m2 (.clk(clk), .a(w1_reg), .b(p2),     .p(m2));

    // Stages 4-5: w1^2*P6, w1^2*P3; delay the other products
    logic [63:0] m6, m3;
    logic [63:0] m5_d1_reg, m5_d2_reg, m2_d1_reg, m2_d2_reg;
    bsc_mul64 u_m6 (.clk(clk), .a(sq), .b(p6), .p(m6));
    bsc_mul64 u_m3 (.clk(clk), .a(sq), .b(p3), .p(m3));

    always_ff @(posedge clk)
    begin
        m5_d1_reg <= m5;
        m5_d2_reg <= m5_d1_reg;
        m2_d1_reg <= m2;
        m2_d2_reg <= m2_d1_reg;
    end

    // Stage 6: var2 and biased var1
    logic [63:0] w2_reg, x_reg;
    always_ff @(posedge clk)
    begin
        w2_reg <= m6 + (m5_d2_reg << 17) + (p4 << 35);
        x_reg  <= sar64(m3, 8) + (m2_d2_reg << 12) + VAR1_BIAS;
    end

    // Stages 7-8: scale var1 by P1; numerator alongside
    logic [63:0] y;
    logic [63:0] pp;
    logic [63:0] diff_reg, num_reg;
    bsc_mul64 u_y (.clk(clk), .a(x_reg), .b(p1), .p(y));

    assign pp = PRESS_BASE - {44'd0, side_reg[ST_ADCP].adcp};

    always_ff @(posedge clk)
    begin
        diff_reg <= (pp << 31) - w2_reg;
        // times 3125
        num_reg  <= (diff_reg << 11) + (diff_reg << 10) + (diff_reg << 5)
                  + (diff_reg << 4) + (diff_reg << 2) + diff_reg;
    end

    // Stage 9: magnitudes and sign for the divider
    logic [63:0]  w1f;
    logic [63:0]  dvd_reg, dvs_reg;
    bsc_div_tag_t dtag_reg;

    assign w1f = sar64(y, 33);

    always_ff @(posedge clk)
    begin
        dvd_reg       <= num_reg[63] ? 64'd0 - num_reg : num_reg;
        dvs_reg       <= w1f[63] ? 64'd0 - w1f : w1f;
        dtag_reg.neg  <= num_reg[63] ^ w1f[63];
        dtag_reg.zero <= (w1f == 64'd0);
    end

    // Divider
    logic [63:0]  quo;
    bsc_div_tag_t qtag;

    bsc_div64 u_div (
        .clk      (clk),
        .dividend (dvd_reg),
        .divisor  (dvs_reg),
        .tag_in   (dtag_reg),
        .quotient (quo),
        .tag_out  (qtag)
    );

    // Signed quotient, then correction terms
    logic [63:0] q_reg;
    logic [63:0] q_d_reg [ST_QUO+1:ST_QUO+4];
    logic        zero_reg [ST_QUO:ST_LAST];
    logic [63:0] s;
    logic [63:0] ss, e1, e2;
    logic [63:0] sum_reg;

    always_ff @(posedge clk)
    begin
        q_reg            <= qtag.neg ? 64'd0 - quo : quo;
        zero_reg[ST_QUO] <= qtag.zero;
        for (int k = ST_QUO + 1; k <= ST_LAST; k++)
        begin
            zero_reg[k] <= zero_reg[k-1];
        end
        q_d_reg[ST_QUO+1] <= q_reg;
        for (int k = ST_QUO + 2; k <= ST_QUO + 4; k++)
        begin
            q_d_reg[k] <= q_d_reg[k-1];
        end
    end

    assign s = sar64(q_reg, 13);

    bsc_mul64 u_ss (.clk(clk), .a(s),                  .b(s),  .p(ss));
    bsc_mul64 u_e1 (.clk(clk), .a(ss),                 .b(p9), .p(e1));
    bsc_mul64 u_e2 (.clk(clk), .a(q_d_reg[ST_QUO+2]),  .b(p8), .p(e2));

    always_ff @(posedge clk)
    begin
        sum_reg <= q_d_reg[ST_QUO+4] + sar64(e1, 25) + sar64(e2, 19);
    end

    // Output registers
    logic        done_reg;
    logic [31:0] temp_out_reg;
    logic [31:0] pres_out_reg;
    logic        pvalid_reg;
    logic [63:0] pres_full;

    assign pres_full = sar64(sum_reg, 8) + (p7 << 4);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= vld_reg[ST_LAST];
        end
    end

    always_ff @(posedge clk)
    begin
        temp_out_reg <= side_reg[ST_LAST].temp;
        pres_out_reg <= zero_reg[ST_LAST] ? 32'd0 : pres_full[31:0];
        pvalid_reg   <= ~zero_reg[ST_LAST];
    end

    assign done              = done_reg;
    assign temperature_centi = $signed(temp_out_reg);
    assign pressure_q24_8    = pres_out_reg;
    assign pressure_valid    = pvalid_reg;

endmodule

// ----- design/bsc_mul64.sv -----
module bsc_mul64 (
    input  logic        clk,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic [63:0] p
);
    import bsc_pkg::*;

    logic [63:0] ll_reg;
    logic [31:0] cross_reg;
    logic [63:0] p_reg;

    // Stage 1: partial products, only the low 64 bits of the full product matter
    always_ff @(posedge clk)
    begin
        ll_reg    <= 64'(a[31:0]) * 64'(b[31:0]);
        cross_reg <= a[31:0] * b[63:32] + a[63:32] * b[31:0];
    end

    // Stage 2: merge
    always_ff @(posedge clk)
    begin
        p_reg <= ll_reg + {cross_reg, 32'd0};
    end

    assign p = p_reg;

endmodule

// ----- design/bsc_div64.sv -----
module bsc_div64 (
    input  logic                  clk,
    input  logic [63:0]           dividend,
    input  logic [63:0]           divisor,
    input  bsc_pkg::bsc_div_tag_t tag_in,
    output logic [63:0]           quotient,
    output bsc_pkg::bsc_div_tag_t tag_out
);
    import bsc_pkg::*;

    logic [63:0]  rem_reg [DIV_STAGES];
    logic [63:0]  quo_reg [DIV_STAGES];
    logic [63:0]  dvs_reg [DIV_STAGES];
    bsc_div_tag_t tag_reg [DIV_STAGES];

    logic [63:0]  rem_next [DIV_STAGES];
    logic [63:0]  quo_next [DIV_STAGES];

    // One restoring step per stage
    always_comb
    begin
        logic [63:0] prem;
        logic [63:0] pquo;
        logic [63:0] pdvs;
        logic [64:0] trial;
        logic [64:0] diff;
        for (int j = 0; j < DIV_STAGES; j++)
        begin
            prem  = (j == 0) ? 64'd0    : rem_reg[(j == 0) ? 0 : j - 1];
            pquo  = (j == 0) ? dividend : quo_reg[(j == 0) ? 0 : j - 1];
            pdvs  = (j == 0) ? divisor  : dvs_reg[(j == 0) ? 0 : j - 1];
            trial = {prem, pquo[63]};
            diff  = trial - {1'b0, pdvs};
            rem_next[j] = diff[64] ? trial[63:0] : diff[63:0];
            quo_next[j] = {pquo[62:0], ~diff[64]};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < DIV_STAGES; j++)
        begin
            rem_reg[j] <= rem_next[j];
            quo_reg[j] <= quo_next[j];
            dvs_reg[j] <= (j == 0) ? divisor : dvs_reg[(j == 0) ? 0 : j - 1];
            tag_reg[j] <= (j == 0) ? tag_in  : tag_reg[(j == 0) ? 0 : j - 1];
        end
    end

    assign quotient = quo_reg[DIV_STAGES-1];
    assign tag_out  = tag_reg[DIV_STAGES-1];

endmodule

// ----- design/bsc_temp.sv -----
module bsc_temp (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic [bsc_pkg::RAW_W-1:0]   raw_temperature,
    input  logic [bsc_pkg::RAW_W-1:0]   raw_pressure,
    input  logic [bsc_pkg::CAL_T_W-1:0] cal,
    output logic                        out_valid,
    output logic [31:0]                 fine,
    output bsc_pkg::bsc_side_t          side
);
    import bsc_pkg::*;

    logic [31:0] adc_t;
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] t3;
    logic [31:0] d;

    logic [3:0]       vld_reg;
    logic [RAW_W-1:0] adcp1_reg, adcp2_reg, adcp3_reg;
    logic [31:0]      a_reg, dd_reg;
    logic [31:0]      v1_reg, m_reg;
    logic [31:0]      fine3_reg, fine4_reg;
    bsc_side_t        side_reg;

    assign adc_t = {12'd0, raw_temperature};
    assign t1    = {16'd0, cal[15:0]};
    assign t2    = {{16{cal[31]}}, cal[31:16]};
    assign t3    = {{16{cal[47]}}, cal[47:32]};
    assign d     = (adc_t >> 4) - t1;

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[2:0], in_valid};
        end
    end

    // Four stages, 32-bit wrapping arithmetic
    always_ff @(posedge clk)
    begin
        a_reg     <= ((adc_t >> 3) - (t1 << 1)) * t2;
        dd_reg    <= d * d;
        adcp1_reg <= raw_pressure;

        v1_reg    <= sar32(a_reg, 11);
        m_reg     <= sar32(dd_reg, 12) * t3;
        adcp2_reg <= adcp1_reg;

        fine3_reg <= v1_reg + sar32(m_reg, 14);
        adcp3_reg <= adcp2_reg;

        fine4_reg     <= fine3_reg;
        side_reg.temp <= sar32((fine3_reg << 2) + fine3_reg + 32'd128, 8);
        side_reg.adcp <= adcp3_reg;
    end

    assign out_valid = vld_reg[3];
    assign fine      = fine4_reg;
    assign side      = side_reg;

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps

module tb;
    import bsc_pkg::*;

    localparam int unsigned LATENCY   = 83;
    localparam int unsigned CYCLE_CAP = 400000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [19:0] raw_pressure = '0;
    logic [19:0] raw_temperature = '0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [63:0] cfg_wdata = '0;
    logic        done;
    logic signed [31:0] temperature_centi;
    logic [31:0] pressure_q24_8;
    logic        pressure_valid;

    typedef struct packed {
        logic [31:0] temp;
        logic [31:0] pres;
        logic        valid;
    } comp_res_t;

    // Shadow copy of the calibration registers
    logic [47:0] cal_t;
    logic [63:0] cal_p1;
    logic [63:0] cal_p2;
    logic [15:0] cal_p9;

    comp_res_t   pending_q[$];
    int unsigned mismatches = 0;
    int unsigned received = 0;
    int unsigned invalid_seen = 0;
    int unsigned cycles = 0;
    int unsigned send_gap_pct = 0;

    barometric_sensor_compensation DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .raw_pressure(raw_pressure), .raw_temperature(raw_temperature),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .done(done), .temperature_centi(temperature_centi),
        .pressure_q24_8(pressure_q24_8), .pressure_valid(pressure_valid)
    );

    always #5 clk = ~clk;

    // Compensation formula, wrapping at 32 bits (temperature) and 64 bits (pressure)
    function automatic comp_res_t compensate(input logic [19:0] adc_p,
                                             input logic [19:0] adc_t);
        comp_res_t r;
        logic signed [31:0] t1, t2, t3, a, d, v1, v2, fine;
        logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic signed [63:0] w1, w2, p, s, e1, e2, na, nb, q;
        t1 = {16'd0, cal_t[15:0]};
        t2 = {{16{cal_t[31]}}, cal_t[31:16]};
        t3 = {{16{cal_t[47]}}, cal_t[47:32]};
        p1 = {48'd0, cal_p1[15:0]};
        p2 = {{48{cal_p1[31]}}, cal_p1[31:16]};
        p3 = {{48{cal_p1[47]}}, cal_p1[47:32]};
        p4 = {{48{cal_p1[63]}}, cal_p1[63:48]};
        p5 = {{48{cal_p2[15]}}, cal_p2[15:0]};
        p6 = {{48{cal_p2[31]}}, cal_p2[31:16]};
        p7 = {{48{cal_p2[47]}}, cal_p2[47:32]};
        p8 = {{48{cal_p2[63]}}, cal_p2[63:48]};
        p9 = {{48{cal_p9[15]}}, cal_p9};
        a = ($signed({15'd0, adc_t[19:3]}) - (t1 <<< 1)) * t2;
        v1 = a >>> 11;
        d = $signed({16'd0, adc_t[19:4]}) - t1;
        v2 = (((d * d) >>> 12) * t3) >>> 14;
        fine = v1 + v2;
        r.temp = (fine * 32'sd5 + 32'sd128) >>> 8;
        w1 = 64'(fine) - 64'sd128000;
        w2 = w1 * w1 * p6;
        w2 = w2 + ((w1 * p5) <<< 17);
        w2 = w2 + (p4 <<< 35);
        w1 = ((w1 * w1 * p3) >>> 8) + ((w1 * p2) <<< 12);
        w1 = (((64'sd1 <<< 47) + w1) * p1) >>> 33;
        if (w1 == 0) begin
            r.pres = '0;
            r.valid = 1'b0;
        end
        else begin
            p = 64'sd1048576 - $signed({44'd0, adc_p});
            na = ((p <<< 31) - w2) * 64'sd3125;
            nb = w1;
            // Unsigned magnitudes avoid the simulator's own overflow rules
            q = 64'($unsigned(na < 0 ? -na : na) / $unsigned(nb < 0 ? -nb : nb));
            p = ((na < 0) != (nb < 0)) ? -q : q;
            s = p >>> 13;
            e1 = (p9 * s * s) >>> 25;
            e2 = (p8 * p) >>> 19;
            p = ((p + e1 + e2) >>> 8) + (p7 <<< 4);
            r.pres = p[31:0];
            r.valid = 1'b1;
        end
        return r;
    endfunction

    // Check each result against the oldest expectation
    always @(posedge clk) begin
        if (rst_n && done) begin
            comp_res_t exp_r;
            received <= received + 1;
            if (!pressure_valid) invalid_seen <= invalid_seen + 1;
            if (pending_q.size() == 0) begin
                mismatches = mismatches + 1;
                if (mismatches <= 10) $display("unexpected result t=%0d p=%0d v=%0b",
                    temperature_centi, pressure_q24_8, pressure_valid);
            end
            else begin
                exp_r = pending_q.pop_front();
                if (temperature_centi !== exp_r.temp || pressure_q24_8 !== exp_r.pres ||
                    pressure_valid !== exp_r.valid) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("mismatch: exp t=%0d p=%0d v=%0b got t=%0d p=%0d v=%0b",
                            $signed(exp_r.temp), exp_r.pres, exp_r.valid,
                            temperature_centi, pressure_q24_8, pressure_valid);
                end
            end
        end
    end

    // Run limit
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("timeout after %0d cycles", cycles);
            $display("status: fail");
            $finish;
        end
    end

    task automatic write_cal(input bsc_cfg_e idx, input logic [63:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        case (idx)
            CFG_TEMP:     cal_t  = value[47:0];
            CFG_PRESS_LO: cal_p1 = value;
            CFG_PRESS_HI: cal_p2 = value;
            CFG_PRESS_P9: cal_p9 = value[15:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic load_cal(input logic [47:0] t, input logic [63:0] a,
                            input logic [63:0] b, input logic [15:0] c);
        write_cal(CFG_TEMP, {16'd0, t});
        write_cal(CFG_PRESS_LO, a);
        write_cal(CFG_PRESS_HI, b);
        write_cal(CFG_PRESS_P9, {48'd0, c});
    endtask

    // Wait until every expected result has arrived plus the pipeline depth
    task automatic drain();
        while (pending_q.size() != 0) @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    // Present one item after random idle cycles; start stays high after
    // acceptance so the next item can follow at once
    task automatic send_item(input logic [19:0] rp, input logic [19:0] rt);
        while (send_gap_pct != 0 && $urandom_range(99, 0) < send_gap_pct) begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        raw_pressure <= rp;
        raw_temperature <= rt;
        @(posedge clk);
        while (busy) @(posedge clk);
        pending_q.push_back(compensate(rp, rt));
    endtask

    typedef struct {
        logic [19:0] rp;
        logic [19:0] rt;
        logic        typed;
        comp_res_t   res;
    } stim_row_t;

    // Typical factory calibration set
    localparam logic [47:0] CAL_T_TYP = {16'hFC18, 16'h6A00, 16'h6B70};
    localparam logic [63:0] CAL_P1_TYP = {16'h0B3C, 16'hD0A4, 16'hD6D0, 16'h9268};
    localparam logic [63:0] CAL_P2_TYP = {16'hEBE8, 16'h3D6C, 16'hFFF9, 16'h008C};
    localparam logic [15:0] CAL_P9_TYP = 16'h1770;

    stim_row_t rows[] = '{
        // all calibration zero: temperature 0, divisor zero
        '{20'd0, 20'd0, 1'b1, '{32'd0, 32'd0, 1'b0}},
        '{20'hFFFFF, 20'hFFFFF, 1'b1, '{32'd0, 32'd0, 1'b0}},
        '{20'h55555, 20'hAAAAA, 1'b1, '{32'd0, 32'd0, 1'b0}},
        '{20'hAAAAA, 20'h55555, 1'b1, '{32'd0, 32'd0, 1'b0}}
    };
    stim_row_t rows_typ[] = '{
        '{20'd0, 20'd0, 1'b0, '{0, 0, 0}},
        '{20'hFFFFF, 20'hFFFFF, 1'b0, '{0, 0, 0}},
        '{20'd415148, 20'd519888, 1'b0, '{0, 0, 0}},
        '{20'd1, 20'hFFFFF, 1'b0, '{0, 0, 0}},
        '{20'hFFFFF, 20'd0, 1'b0, '{0, 0, 0}},
        '{20'h80000, 20'h80000, 1'b0, '{0, 0, 0}},
        '{20'h7FFFF, 20'h7FFFF, 1'b0, '{0, 0, 0}}
    };

    // Walk a stimulus table; typed rows replace the predicted result
    task automatic run_rows(input stim_row_t tbl[]);
        foreach (tbl[k]) begin
            send_item(tbl[k].rp, tbl[k].rt);
            if (tbl[k].typed) pending_q[pending_q.size() - 1] = tbl[k].res;
        end
        start <= 1'b0;
    endtask

    task automatic random_phase(input int unsigned n);
        int unsigned i;
        int unsigned kind;
        logic [19:0] rp, rt;
        for (i = 0; i < n; i++) begin
            kind = $urandom_range(9, 0);
            rp = 20'($urandom);
            rt = 20'($urandom);
            if (kind < 2) begin
                rp = kind[0] ? 20'hFFFFF : 20'd0;
            end
            else if (kind < 6) begin
                // realistic readings
                rp = 20'($urandom_range(450000, 200000));
                rt = 20'($urandom_range(600000, 400000));
            end
            send_item(rp, rt);
        end
        start <= 1'b0;
    endtask

    task automatic random_cal();
        load_cal(48'({$urandom, $urandom}), {$urandom, $urandom},
                 {$urandom, $urandom}, 16'($urandom));
    endtask

    initial begin
        cal_t = '0;
        cal_p1 = '0;
        cal_p2 = '0;
        cal_p9 = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed rows after reset: expected values typed in
        run_rows(rows);
        drain();

        // Typical calibration, then extreme calibration words
        load_cal(CAL_T_TYP, CAL_P1_TYP, CAL_P2_TYP, CAL_P9_TYP);
        run_rows(rows_typ);
        drain();
        load_cal(48'hFFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF);
        run_rows(rows_typ);
        drain();
        load_cal(48'h8000_8000_FFFF, 64'h8000_8000_8000_FFFF, 64'h8000_8000_8000_8000, 16'h8000);
        run_rows(rows_typ);
        drain();
        load_cal(48'h7FFF_7FFF_0000, 64'h7FFF_7FFF_7FFF_0001, 64'h7FFF_7FFF_7FFF_7FFF, 16'h7FFF);
        run_rows(rows_typ);
        drain();

        // Random phases: sender gaps, then heavy gaps, then back to back
        send_gap_pct = 13;
        load_cal(CAL_T_TYP, CAL_P1_TYP, CAL_P2_TYP, CAL_P9_TYP);
        random_phase(250);
        drain();
        random_cal();
        random_phase(100);
        drain();
        send_gap_pct = 84;
        load_cal(CAL_T_TYP, CAL_P1_TYP ^ 64'h0000_0000_0000_0F0F, CAL_P2_TYP, CAL_P9_TYP);
        random_phase(150);
        drain();
        random_cal();
        random_phase(50);
        drain();
        send_gap_pct = 0;
        load_cal(CAL_T_TYP, CAL_P1_TYP, CAL_P2_TYP, CAL_P9_TYP);
        random_phase(300);
        drain();
        random_cal();
        random_phase(100);
        drain();
        // P1 zero forces the zero divisor with live temperature
        load_cal(CAL_T_TYP, {$urandom, $urandom} & ~64'hFFFF, CAL_P2_TYP, CAL_P9_TYP);
        random_phase(50);
        drain();

        $display("checked %0d results over %0d calibration sets, %0d with zero divisor",
            received, 12, invalid_seen);
        if (mismatches == 0 && pending_q.size() == 0) begin
            $display("status: pass");
        end
        else begin
            $display("%0d mismatches, %0d results missing", mismatches, pending_q.size());
            $display("status: fail");
        end
        $finish;
    end
endmodule

// ----- files.f -----
design/bsc_pkg.sv
design/bsc_mul64.sv
design/bsc_div64.sv
design/bsc_temp.sv
design/barometric_sensor_compensation.sv
tb/sv/tb.sv
